// ===== rtl/psm_pkg.sv =====
// Shared types, codes and constants for the primary-sample mutation pipeline.
// Holds the Q1.16 table of 2^(-i/64) and the mode/kind decode functions.
// No dependencies.
package psm_pkg;

    localparam int VALUE_W           = 32;
    localparam int CFG_INDEX_W       = 1;
    localparam int CFG_DATA_W        = 32;
    localparam int MODE_W            = 3;
    localparam int KIND_W            = 3;
    localparam int BIN_W             = 6;
    localparam int EXP_W             = 17;
    localparam int PROD_W            = VALUE_W + EXP_W - 1;
    localparam int SPECTRUM_SIZE_DEF = 64;

    localparam logic [VALUE_W-1:0] STEP_SCALE_RST = 32'h0040_0000;
    localparam logic [VALUE_W-1:0] SCALE_WAVE     = 32'h1000_0000;
    localparam logic [VALUE_W-1:0] SCALE_INDEX    = 32'h0800_0000;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SCALE    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MUTATION_MODE = 1'd1;

    // mutation modes
    localparam logic [MODE_W-1:0] MODE_INIT        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FULL        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FOCUS_LIGHT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FOCUS_EYE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIGHT_ONLY  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_EYE_ONLY    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RST         = MODE_FULL;

    // coordinate kinds
    localparam logic [KIND_W-1:0] KIND_WAVE        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LIGHT_COORD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LIGHT_INDEX = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EYE_COORD   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EYE_INDEX   = 3'd4;

    typedef enum logic [1:0] {
        ACT_COPY   = 2'd0,
        ACT_MUTATE = 2'd1,
        ACT_FRESH  = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        GRP_WAVE  = 2'd0,
        GRP_LIGHT = 2'd1,
        GRP_EYE   = 2'd2,
        GRP_NONE  = 2'd3
    } grp_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] prev;
        logic [VALUE_W-1:0] rstep;
        logic               dir;
        logic [VALUE_W-1:0] fresh;
    } psm_in_t;

    typedef struct packed {
        act_t               act;
        logic               dir;
        logic [VALUE_W-1:0] prev;
        logic [VALUE_W-1:0] fresh;
        logic [PROD_W-1:0]  prod;
        logic [1:0]         shift;
        logic               is_wave;
    } psm_mul_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_wave;
    } psm_val_t;

    function automatic grp_t kind_group(input logic [KIND_W-1:0] kind);
        grp_t g;
        case (kind)
            KIND_WAVE:        g = GRP_WAVE;
            KIND_LIGHT_COORD: g = GRP_LIGHT;
            KIND_LIGHT_INDEX: g = GRP_LIGHT;
            KIND_EYE_COORD:   g = GRP_EYE;
            KIND_EYE_INDEX:   g = GRP_EYE;
            default:          g = GRP_NONE;
        endcase
        return g;
    endfunction

    function automatic act_t pick_action(input logic [MODE_W-1:0] mode, input grp_t grp);
        act_t a;
        if (grp == GRP_NONE) begin
            a = ACT_COPY;
        end
        else begin
            case (mode)
                MODE_INIT:        a = ACT_FRESH;
                MODE_FULL:        a = ACT_MUTATE;
                MODE_FOCUS_LIGHT: a = (grp == GRP_EYE) ? ACT_FRESH : ACT_MUTATE;
                MODE_FOCUS_EYE:   a = (grp == GRP_LIGHT) ? ACT_FRESH : ACT_MUTATE;
                MODE_LIGHT_ONLY:  a = (grp == GRP_LIGHT) ? ACT_MUTATE : ACT_COPY;
                MODE_EYE_ONLY:    a = (grp == GRP_EYE) ? ACT_MUTATE : ACT_COPY;
                default:          a = ACT_COPY;
            endcase
        end
        return a;
    endfunction

    // round(65536 * 2^(-i/64))
    function automatic logic [EXP_W-1:0] exp_lut(input logic [5:0] i);
        logic [EXP_W-1:0] t;
        case (i)
            6'd0:  t = 17'd65536;  6'd1:  t = 17'd64830;
            6'd2:  t = 17'd64132;  6'd3:  t = 17'd63441;
            6'd4:  t = 17'd62757;  6'd5:  t = 17'd62081;
            6'd6:  t = 17'd61413;  6'd7:  t = 17'd60751;
            6'd8:  t = 17'd60097;  6'd9:  t = 17'd59449;
            6'd10: t = 17'd58809;  6'd11: t = 17'd58176;
            6'd12: t = 17'd57549;  6'd13: t = 17'd56929;
            6'd14: t = 17'd56316;  6'd15: t = 17'd55709;
            6'd16: t = 17'd55109;  6'd17: t = 17'd54515;
            6'd18: t = 17'd53928;  6'd19: t = 17'd53347;
            6'd20: t = 17'd52773;  6'd21: t = 17'd52204;
            6'd22: t = 17'd51642;  6'd23: t = 17'd51085;
            6'd24: t = 17'd50535;  6'd25: t = 17'd49991;
            6'd26: t = 17'd49452;  6'd27: t = 17'd48920;
            6'd28: t = 17'd48393;  6'd29: t = 17'd47871;
            6'd30: t = 17'd47356;  6'd31: t = 17'd46846;
            6'd32: t = 17'd46341;  6'd33: t = 17'd45842;
            6'd34: t = 17'd45348;  6'd35: t = 17'd44859;
            6'd36: t = 17'd44376;  6'd37: t = 17'd43898;
            6'd38: t = 17'd43425;  6'd39: t = 17'd42958;
            6'd40: t = 17'd42495;  6'd41: t = 17'd42037;
            6'd42: t = 17'd41584;  6'd43: t = 17'd41136;
            6'd44: t = 17'd40693;  6'd45: t = 17'd40255;
            6'd46: t = 17'd39821;  6'd47: t = 17'd39392;
            6'd48: t = 17'd38968;  6'd49: t = 17'd38548;
            6'd50: t = 17'd38133;  6'd51: t = 17'd37722;
            6'd52: t = 17'd37316;  6'd53: t = 17'd36914;
            6'd54: t = 17'd36516;  6'd55: t = 17'd36123;
            6'd56: t = 17'd35734;  6'd57: t = 17'd35349;
            6'd58: t = 17'd34968;  6'd59: t = 17'd34591;
            6'd60: t = 17'd34219;  6'd61: t = 17'd33850;
            6'd62: t = 17'd33486;  6'd63: t = 17'd33125;
            default: t = 17'd65536;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/psm_mul_stage.sv =====
// Decode stage: picks action and scale, multiplies scale by the 2^(-i/64) entry.
// Depends on psm_pkg.
module psm_mul_stage (
    input  logic                            clk,
    input  logic                            en,
    input  psm_pkg::psm_in_t                din,
    input  logic [psm_pkg::VALUE_W-1:0]     step_scale,
    input  logic [psm_pkg::MODE_W-1:0]      mutation_mode,
    output psm_pkg::psm_mul_t               dout
);
    import psm_pkg::*;

    grp_t               grp;
    logic [VALUE_W-1:0] scale;
    psm_mul_t           mul_next;
    psm_mul_t           mul_reg;

    always_comb
    begin
        grp = kind_group(din.kind);
        case (din.kind)
            KIND_WAVE:        scale = SCALE_WAVE;
            KIND_LIGHT_INDEX: scale = SCALE_INDEX;
            KIND_EYE_INDEX:   scale = SCALE_INDEX;
            default:          scale = step_scale;
        endcase
        mul_next.act     = pick_action(mutation_mode, grp);
        mul_next.dir     = din.dir;
        mul_next.prev    = din.prev;
        mul_next.fresh   = din.fresh;
        mul_next.prod    = PROD_W'(scale) * PROD_W'(exp_lut(din.rstep[29:24]));
        mul_next.shift   = din.rstep[31:30];
        mul_next.is_wave = (din.kind == KIND_WAVE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg <= mul_next;
        end
    end

    assign dout = mul_reg;

endmodule

// ===== rtl/psm_update_stage.sv =====
// Update stage: shifts the product into a step and applies copy, mutate or fresh.
// Depends on psm_pkg.
module psm_update_stage (
    input  logic               clk,
    input  logic               en,
    input  psm_pkg::psm_mul_t  din,
    output psm_pkg::psm_val_t  dout
);
    import psm_pkg::*;

    logic [PROD_W-1:0]  shifted;
    logic [VALUE_W-1:0] step;
    psm_val_t           val_next;
    psm_val_t           val_reg;

    always_comb
    begin
        shifted = din.prod >> (5'd16 + {3'b000, din.shift});
        step    = shifted[VALUE_W-1:0];
        case (din.act)
            ACT_FRESH:  val_next.value = din.fresh;
            ACT_MUTATE: val_next.value = din.dir ? (din.prev - step) : (din.prev + step);
            default:    val_next.value = din.prev;
        endcase
        val_next.is_wave = din.is_wave;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
        end
    end

    assign dout = val_reg;

endmodule

// ===== rtl/psm_bin_stage.sv =====
// Output stage: registers the new value and its spectrum bin.
// Depends on psm_pkg.
module psm_bin_stage #(
    parameter int SPECTRUM_SIZE = psm_pkg::SPECTRUM_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  psm_pkg::psm_val_t             din,
    output logic [psm_pkg::VALUE_W-1:0]   new_value,
    output logic [psm_pkg::BIN_W-1:0]     wave_bin
);
    import psm_pkg::*;

    localparam int SIZE_W = $clog2(SPECTRUM_SIZE + 1);
    localparam int BPW    = (SIZE_W > BIN_W) ? VALUE_W + SIZE_W : VALUE_W + BIN_W;

    logic [BPW-1:0]     bin_prod;
    logic [VALUE_W-1:0] value_reg;
    logic [BIN_W-1:0]   bin_next;
    logic [BIN_W-1:0]   bin_reg;

    always_comb
    begin
        bin_prod = BPW'(din.value) * BPW'(SPECTRUM_SIZE);
        // keep only the low bits of the integer part
        bin_next = din.is_wave ? bin_prod[VALUE_W+BIN_W-1:VALUE_W] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= din.value;
            bin_reg   <= bin_next;
        end
    end

    assign new_value = value_reg;
    assign wave_bin  = bin_reg;

endmodule

// ===== rtl/primary_sample_mutation.sv =====
// Primary-sample coordinate mutation, four-stage pipeline.
// An accepted request is loaded into the input register, then passes through the
// multiply, update and bin/output registers in that order.
// Throughput: one request per cycle while out_stall is low; each stage holds one
// request, and bubbles collapse when the output stalls.
// Reset (async, active low): pipeline empty, step_scale = 1/1024, mode = full.
module primary_sample_mutation #(
    parameter int SPECTRUM_SIZE = psm_pkg::SPECTRUM_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [psm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [psm_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [psm_pkg::KIND_W-1:0]        coord_kind,
    input  logic [psm_pkg::VALUE_W-1:0]       prev_value,
    input  logic [psm_pkg::VALUE_W-1:0]       rand_step,
    input  logic                              rand_dir,
    input  logic [psm_pkg::VALUE_W-1:0]       rand_fresh,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [psm_pkg::VALUE_W-1:0]       new_value,
    output logic [psm_pkg::BIN_W-1:0]         wave_bin
);
    import psm_pkg::*;

    // configuration registers
    logic [VALUE_W-1:0] step_scale_reg;
    logic [MODE_W-1:0]  mode_reg;

    // per-stage valid bits: input, multiply, update, output
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic en1, en2, en3, en4;

    psm_in_t  in_next;
    psm_in_t  in_reg;
    psm_mul_t mul_q;
    psm_val_t val_q;

    // Load a stage when it is empty or its contents move on this cycle.
    always_comb
    begin
        en4 = !v4_reg || !out_stall;
        en3 = !v3_reg || en4;
        en2 = !v2_reg || en3;
        en1 = !v1_reg || en2;

        v1_next = en1 ? in_valid : v1_reg;
        v2_next = en2 ? v1_reg   : v2_reg;
        v3_next = en3 ? v2_reg   : v3_reg;
        v4_next = en4 ? v3_reg   : v4_reg;
    end

    assign in_stall  = !en1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Take configuration writes at any time; the host must write only when idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_scale_reg <= STEP_SCALE_RST;
            mode_reg       <= MODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_SCALE:    step_scale_reg <= cfg_data[VALUE_W-1:0];
                REG_MUTATION_MODE: mode_reg       <= cfg_data[MODE_W-1:0];
                default:           mode_reg       <= mode_reg;
            endcase
        end
    end

    // Capture the request fields; payload needs no reset.
    always_comb
    begin
        in_next.kind  = coord_kind;
        in_next.prev  = prev_value;
        in_next.rstep = rand_step;
        in_next.dir   = rand_dir;
        in_next.fresh = rand_fresh;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            in_reg <= in_next;
        end
    end

    // Decode the action and form scale * 2^(-i/64).
    psm_mul_stage u_mul (
        .clk           (clk),
        .en            (en2),
        .din           (in_reg),
        .step_scale    (step_scale_reg),
        .mutation_mode (mode_reg),
        .dout          (mul_q)
    );

    // Shift by 16 + k, then add, subtract, copy or replace; wraps modulo one.
    psm_update_stage u_upd (
        .clk  (clk),
        .en   (en3),
        .din  (mul_q),
        .dout (val_q)
    );

    // Hold the result and derive the wavelength bin.
    psm_bin_stage #(
        .SPECTRUM_SIZE (SPECTRUM_SIZE)
    ) u_bin (
        .clk       (clk),
        .en        (en4),
        .din       (val_q),
        .new_value (new_value),
        .wave_bin  (wave_bin)
    );

endmodule
